/* src/asl_pkg.sv */
// Shared types and codes for the assembler source lexer.
// Lexer state, quote kind, result record and token and error codes.
// No dependencies.
`timescale 1ns / 1ps

package asl_pkg;

	typedef enum logic [4:0] {
		ST_TOP, ST_NEU, ST_WHITE, ST_COMMENT, ST_COLON, ST_EQ, ST_VBAR, ST_AMP,
		ST_LT, ST_GT, ST_BANG, ST_SYM, ST_BITPRE, ST_QUOTED, ST_ESC, ST_ZERO,
		ST_BIN, ST_OCT, ST_DEC, ST_HEX
	} lex_state_t;

	typedef enum logic [1:0] {Q_NONE, Q_STR, Q_CHR, Q_BIT} quote_t;

	typedef enum logic [1:0] {KIND_TOKEN, KIND_TEXT, KIND_ERROR} item_kind_t;

	localparam logic [5:0] T_EOL   = 6'd0;
	localparam logic [5:0] T_WHITE = 6'd1;
	localparam logic [5:0] T_HAT   = 6'd2;
	localparam logic [5:0] T_COMMA = 6'd3;
	localparam logic [5:0] T_PLUS  = 6'd4;
	localparam logic [5:0] T_MINUS = 6'd5;
	localparam logic [5:0] T_AST   = 6'd6;
	localparam logic [5:0] T_SLASH = 6'd7;
	localparam logic [5:0] T_PCT   = 6'd8;
	localparam logic [5:0] T_PARL  = 6'd9;
	localparam logic [5:0] T_PARR  = 6'd10;
	localparam logic [5:0] T_BRKL  = 6'd11;
	localparam logic [5:0] T_BRKR  = 6'd12;
	localparam logic [5:0] T_BRCL  = 6'd13;
	localparam logic [5:0] T_BRCR  = 6'd14;
	localparam logic [5:0] T_CC    = 6'd15;
	localparam logic [5:0] T_COLON = 6'd16;
	localparam logic [5:0] T_EQEQ  = 6'd17;
	localparam logic [5:0] T_EQ    = 6'd18;
	localparam logic [5:0] T_VV    = 6'd19;
	localparam logic [5:0] T_V     = 6'd20;
	localparam logic [5:0] T_AA    = 6'd21;
	localparam logic [5:0] T_A     = 6'd22;
	localparam logic [5:0] T_LE    = 6'd23;
	localparam logic [5:0] T_LL    = 6'd24;
	localparam logic [5:0] T_LTOK  = 6'd25;
	localparam logic [5:0] T_GE    = 6'd26;
	localparam logic [5:0] T_GG    = 6'd27;
	localparam logic [5:0] T_GTOK  = 6'd28;
	localparam logic [5:0] T_NE    = 6'd29;
	localparam logic [5:0] T_BANG  = 6'd30;
	localparam logic [5:0] T_SYM   = 6'd31;
	localparam logic [5:0] T_STR   = 6'd32;
	localparam logic [5:0] T_NUM   = 6'd33;
	localparam logic [5:0] T_BIT   = 6'd34;

	localparam logic [2:0] E_INVALID  = 3'd0;
	localparam logic [2:0] E_UNCLOSED = 3'd1;
	localparam logic [2:0] E_CHARLEN  = 3'd2;
	localparam logic [2:0] E_BADESC   = 3'd3;
	localparam logic [2:0] E_OCT89    = 3'd4;

	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_CR = 8'h0D;

	typedef struct packed {
		lex_state_t  state;
		quote_t      quote;
		logic [2:0]  len;
	} lex_regs_t;

	typedef struct packed {
		item_kind_t  kind;
		logic [5:0]  code;
		logic [7:0]  text;
		logic [2:0]  err;
	} res_t;

	// Up to three results per source byte; cnt gives how many slots hold one.
	typedef struct packed {
		logic [1:0]     cnt;
		res_t [2:0]     slot;
	} step_out_t;

endpackage

/* src/asl_step.sv */
// Next-state and result logic of the lexer for one source byte.
// Folds the re-examination of a pushed-back byte into a second, neutral stage.
// Depends on asl_pkg.
`timescale 1ns / 1ps

module asl_step #(
	parameter int VALUE_WIDTH = 32
) (
	input  asl_pkg::lex_regs_t       cur,
	input  logic [VALUE_WIDTH-1:0]   cur_acc,
	input  logic [7:0]               ch,
	output asl_pkg::lex_regs_t       nxt,
	output logic [VALUE_WIDTH-1:0]   nxt_acc,
	output asl_pkg::step_out_t       res,
	output logic [VALUE_WIDTH-1:0]   num_value
);

	localparam logic [7:0] CH_EOF    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_PCT    = 8'h25;
	localparam logic [7:0] CH_AMP    = 8'h26;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_PARL   = 8'h28;
	localparam logic [7:0] CH_PARR   = 8'h29;
	localparam logic [7:0] CH_AST    = 8'h2A;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_D0     = 8'h30;
	localparam logic [7:0] CH_D1     = 8'h31;
	localparam logic [7:0] CH_D7     = 8'h37;
	localparam logic [7:0] CH_D8     = 8'h38;
	localparam logic [7:0] CH_D9     = 8'h39;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_UC_A   = 8'h41;
	localparam logic [7:0] CH_UC_F   = 8'h46;
	localparam logic [7:0] CH_UC_Z   = 8'h5A;
	localparam logic [7:0] CH_BRKL   = 8'h5B;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_BRKR   = 8'h5D;
	localparam logic [7:0] CH_HAT    = 8'h5E;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_LC_A   = 8'h61;
	localparam logic [7:0] CH_LC_B   = 8'h62;
	localparam logic [7:0] CH_LC_F   = 8'h66;
	localparam logic [7:0] CH_LC_N   = 8'h6E;
	localparam logic [7:0] CH_LC_R   = 8'h72;
	localparam logic [7:0] CH_LC_X   = 8'h78;
	localparam logic [7:0] CH_LC_Z   = 8'h7A;
	localparam logic [7:0] CH_BRCL   = 8'h7B;
	localparam logic [7:0] CH_VBAR   = 8'h7C;
	localparam logic [7:0] CH_BRCR   = 8'h7D;
	localparam logic [2:0] LEN_MAX   = 3'd7;

	function automatic logic is_end(input logic [7:0] c);
		return (c == CH_EOF) || (c == asl_pkg::CH_LF);
	endfunction

	function automatic logic is_white(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_TAB);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_D0) && (c <= CH_D9);
	endfunction

	function automatic logic is_first(input logic [7:0] c);
		return ((c >= CH_LC_A) && (c <= CH_LC_Z)) || ((c >= CH_UC_A) && (c <= CH_UC_Z))
			|| (c == CH_UNDER) || (c == CH_DOT);
	endfunction

	function automatic asl_pkg::res_t mk_tok(input logic [5:0] code);
		asl_pkg::res_t r;
		r = '0;
		r.kind = asl_pkg::KIND_TOKEN;
		r.code = code;
		return r;
	endfunction

	function automatic asl_pkg::res_t mk_txt(input logic [7:0] c);
		asl_pkg::res_t r;
		r = '0;
		r.kind = asl_pkg::KIND_TEXT;
		r.text = c;
		return r;
	endfunction

	function automatic asl_pkg::res_t mk_err(input logic [2:0] e);
		asl_pkg::res_t r;
		r = '0;
		r.kind = asl_pkg::KIND_ERROR;
		r.err = e;
		return r;
	endfunction

	always_comb begin
		logic [1:0]     a_n;
		asl_pkg::res_t  a0;
		asl_pkg::res_t  a1;
		asl_pkg::res_t  b;
		logic           b_v;
		logic           reexam;
		logic           top_mode;
		logic           add;
		logic [7:0]     content;
		logic [7:0]     border;
		logic [7:0]     p_sec;
		logic [5:0]     p_both;
		logic [5:0]     p_one;
		logic [3:0]     hex_d;
		logic           hex_ok;

		nxt = cur;
		nxt_acc = cur_acc;
		num_value = '0;
		a_n = 2'd0;
		a0 = '0;
		a1 = '0;
		b = '0;
		b_v = 1'b0;
		reexam = 1'b0;
		top_mode = 1'b0;
		add = 1'b0;
		content = 8'h00;
		border = (cur.quote == asl_pkg::Q_CHR) ? CH_SQUOTE : CH_DQUOTE;

		// second character and token codes of the two-character operators
		case (cur.state)
			asl_pkg::ST_COLON: begin
				p_sec = CH_COLON; p_both = asl_pkg::T_CC;   p_one = asl_pkg::T_COLON;
			end
			asl_pkg::ST_VBAR: begin
				p_sec = CH_VBAR;  p_both = asl_pkg::T_VV;   p_one = asl_pkg::T_V;
			end
			asl_pkg::ST_AMP: begin
				p_sec = CH_AMP;   p_both = asl_pkg::T_AA;   p_one = asl_pkg::T_A;
			end
			asl_pkg::ST_LT: begin
				p_sec = CH_EQ;    p_both = asl_pkg::T_LE;   p_one = asl_pkg::T_LTOK;
			end
			asl_pkg::ST_GT: begin
				p_sec = CH_EQ;    p_both = asl_pkg::T_GE;   p_one = asl_pkg::T_GTOK;
			end
			asl_pkg::ST_BANG: begin
				p_sec = CH_EQ;    p_both = asl_pkg::T_NE;   p_one = asl_pkg::T_BANG;
			end
			default: begin
				p_sec = CH_EQ;    p_both = asl_pkg::T_EQEQ; p_one = asl_pkg::T_EQ;
			end
		endcase

		hex_ok = 1'b1;
		if (is_digit(ch))
			hex_d = ch[3:0];
		else if (((ch >= CH_LC_A) && (ch <= CH_LC_F)) || ((ch >= CH_UC_A) && (ch <= CH_UC_F)))
			hex_d = ch[3:0] + 4'd9;
		else begin
			hex_d = 4'd0;
			hex_ok = 1'b0;
		end

		// first stage: the pending state
		case (cur.state)
			asl_pkg::ST_TOP: begin
				reexam = 1'b1;
				top_mode = 1'b1;
			end
			asl_pkg::ST_NEU: reexam = 1'b1;
			asl_pkg::ST_WHITE: begin
				if (!is_white(ch)) begin
					a0 = mk_tok(asl_pkg::T_WHITE);
					a_n = 2'd1;
					nxt.state = asl_pkg::ST_NEU;
					reexam = 1'b1;
				end
			end
			asl_pkg::ST_COMMENT: begin
				if (is_end(ch)) begin
					a0 = mk_tok(asl_pkg::T_EOL);
					a_n = 2'd1;
					nxt.state = asl_pkg::ST_TOP;
				end
			end
			asl_pkg::ST_COLON, asl_pkg::ST_EQ, asl_pkg::ST_VBAR, asl_pkg::ST_AMP,
			asl_pkg::ST_LT, asl_pkg::ST_GT, asl_pkg::ST_BANG: begin
				a_n = 2'd1;
				nxt.state = asl_pkg::ST_NEU;
				if ((cur.state == asl_pkg::ST_LT) && (ch == CH_LT))
					a0 = mk_tok(asl_pkg::T_LL);
				else if ((cur.state == asl_pkg::ST_GT) && (ch == CH_GT))
					a0 = mk_tok(asl_pkg::T_GG);
				else if (ch == p_sec)
					a0 = mk_tok(p_both);
				else begin
					a0 = mk_tok(p_one);
					reexam = 1'b1;
				end
			end
			asl_pkg::ST_SYM: begin
				a_n = 2'd1;
				if (is_first(ch) || is_digit(ch))
					a0 = mk_txt(ch);
				else begin
					a0 = mk_tok(asl_pkg::T_SYM);
					nxt.state = asl_pkg::ST_NEU;
					reexam = 1'b1;
				end
			end
			asl_pkg::ST_BITPRE: begin
				if (ch == CH_DQUOTE) begin
					nxt.quote = asl_pkg::Q_BIT;
					nxt.len = 3'd0;
					nxt.state = asl_pkg::ST_QUOTED;
				end else begin
					// lone b: emit it as symbol text, then go on as a symbol
					a0 = mk_txt(CH_LC_B);
					a_n = 2'd2;
					nxt.state = asl_pkg::ST_SYM;
					if (is_first(ch) || is_digit(ch))
						a1 = mk_txt(ch);
					else begin
						a1 = mk_tok(asl_pkg::T_SYM);
						nxt.state = asl_pkg::ST_NEU;
						reexam = 1'b1;
					end
				end
			end
			asl_pkg::ST_QUOTED: begin
				if (is_end(ch)) begin
					a0 = mk_err(asl_pkg::E_UNCLOSED);
					a_n = 2'd1;
				end else if (ch == border) begin
					nxt.state = asl_pkg::ST_NEU;
					a_n = 2'd1;
					case (cur.quote)
						asl_pkg::Q_STR: a0 = mk_tok(asl_pkg::T_STR);
						asl_pkg::Q_BIT: a0 = mk_tok(asl_pkg::T_BIT);
						asl_pkg::Q_CHR: begin
							if (cur.len > 3'd1)
								a0 = mk_err(asl_pkg::E_CHARLEN);
							else begin
								a0 = mk_txt(ch);
								a1 = mk_tok(asl_pkg::T_NUM);
								a_n = 2'd2;
								// empty literal gives the quote's own code
								num_value = (cur.len == 3'd0) ? VALUE_WIDTH'(CH_SQUOTE) : cur_acc;
							end
						end
						default: a_n = 2'd0;
					endcase
				end else if (ch == CH_BSLASH)
					nxt.state = asl_pkg::ST_ESC;
				else begin
					add = 1'b1;
					content = ch;
				end
			end
			asl_pkg::ST_ESC: begin
				nxt.state = asl_pkg::ST_QUOTED;
				add = 1'b1;
				case (ch)
					CH_DQUOTE, CH_SQUOTE, CH_BSLASH: content = ch;
					CH_LC_N: content = asl_pkg::CH_LF;
					CH_LC_R: content = asl_pkg::CH_CR;
					CH_D0:   content = 8'h00;
					default: begin
						add = 1'b0;
						a0 = mk_err(asl_pkg::E_BADESC);
						a_n = 2'd1;
					end
				endcase
			end
			asl_pkg::ST_ZERO: begin
				a_n = 2'd1;
				if (ch == CH_LC_B) begin
					a0 = mk_txt(ch);
					nxt.state = asl_pkg::ST_BIN;
				end else if ((ch >= CH_D0) && (ch <= CH_D7)) begin
					a0 = mk_txt(ch);
					nxt_acc = VALUE_WIDTH'(ch[2:0]);
					nxt.state = asl_pkg::ST_OCT;
				end else if ((ch == CH_D8) || (ch == CH_D9)) begin
					a0 = mk_err(asl_pkg::E_OCT89);
					nxt.state = asl_pkg::ST_OCT;
				end else if (ch == CH_LC_X) begin
					a0 = mk_txt(ch);
					nxt.state = asl_pkg::ST_HEX;
				end else begin
					a0 = mk_tok(asl_pkg::T_NUM);
					num_value = cur_acc;
					nxt.state = asl_pkg::ST_NEU;
					reexam = 1'b1;
				end
			end
			asl_pkg::ST_BIN: begin
				a_n = 2'd1;
				if ((ch == CH_D0) || (ch == CH_D1)) begin
					a0 = mk_txt(ch);
					nxt_acc = (cur_acc << 1) + VALUE_WIDTH'(ch[0]);
				end else begin
					a0 = mk_tok(asl_pkg::T_NUM);
					num_value = cur_acc;
					nxt.state = asl_pkg::ST_NEU;
					reexam = 1'b1;
				end
			end
			asl_pkg::ST_OCT: begin
				a_n = 2'd1;
				if ((ch >= CH_D0) && (ch <= CH_D7)) begin
					a0 = mk_txt(ch);
					nxt_acc = (cur_acc << 3) + VALUE_WIDTH'(ch[2:0]);
				end else if ((ch == CH_D8) || (ch == CH_D9))
					a0 = mk_err(asl_pkg::E_OCT89);
				else begin
					a0 = mk_tok(asl_pkg::T_NUM);
					num_value = cur_acc;
					nxt.state = asl_pkg::ST_NEU;
					reexam = 1'b1;
				end
			end
			asl_pkg::ST_DEC: begin
				a_n = 2'd1;
				if (is_digit(ch)) begin
					a0 = mk_txt(ch);
					nxt_acc = (cur_acc << 3) + (cur_acc << 1) + VALUE_WIDTH'(ch[3:0]);
				end else begin
					a0 = mk_tok(asl_pkg::T_NUM);
					num_value = cur_acc;
					nxt.state = asl_pkg::ST_NEU;
					reexam = 1'b1;
				end
			end
			asl_pkg::ST_HEX: begin
				a_n = 2'd1;
				if (hex_ok) begin
					a0 = mk_txt(ch);
					nxt_acc = (cur_acc << 4) + VALUE_WIDTH'(hex_d);
				end else begin
					a0 = mk_tok(asl_pkg::T_NUM);
					num_value = cur_acc;
					nxt.state = asl_pkg::ST_NEU;
					reexam = 1'b1;
				end
			end
			default: begin
				nxt.state = asl_pkg::ST_NEU;
				reexam = 1'b1;
			end
		endcase

		// literal content: text byte, first character value, saturating length
		if (add) begin
			a0 = mk_txt(content);
			a_n = 2'd1;
			if ((cur.quote == asl_pkg::Q_CHR) && (cur.len == 3'd0))
				nxt_acc = VALUE_WIDTH'(content);
			if (cur.len != LEN_MAX)
				nxt.len = cur.len + 3'd1;
		end

		// second stage: the byte seen in the neutral state
		if (reexam) begin
			if (is_end(ch)) begin
				if (!top_mode) begin
					b = mk_tok(asl_pkg::T_EOL);
					b_v = 1'b1;
					nxt.state = asl_pkg::ST_TOP;
				end
			end else begin
				nxt.state = asl_pkg::ST_NEU;
				if (is_white(ch))
					nxt.state = asl_pkg::ST_WHITE;
				else if (ch == CH_DQUOTE) begin
					nxt.quote = asl_pkg::Q_STR;
					nxt.len = 3'd0;
					nxt.state = asl_pkg::ST_QUOTED;
				end else if (ch == CH_SQUOTE) begin
					nxt.quote = asl_pkg::Q_CHR;
					nxt.len = 3'd0;
					b = mk_txt(ch);
					b_v = 1'b1;
					nxt.state = asl_pkg::ST_QUOTED;
				end else if (ch == CH_LC_B)
					nxt.state = asl_pkg::ST_BITPRE;
				else if (is_first(ch)) begin
					b = mk_txt(ch);
					b_v = 1'b1;
					nxt.state = asl_pkg::ST_SYM;
				end else if (ch == CH_D0) begin
					nxt_acc = '0;
					b = mk_txt(ch);
					b_v = 1'b1;
					nxt.state = asl_pkg::ST_ZERO;
				end else if (is_digit(ch)) begin
					// first decimal digit taken at once
					nxt_acc = VALUE_WIDTH'(ch[3:0]);
					b = mk_txt(ch);
					b_v = 1'b1;
					nxt.state = asl_pkg::ST_DEC;
				end else begin
					case (ch)
						CH_SEMI:  nxt.state = asl_pkg::ST_COMMENT;
						CH_COLON: nxt.state = asl_pkg::ST_COLON;
						CH_EQ:    nxt.state = asl_pkg::ST_EQ;
						CH_VBAR:  nxt.state = asl_pkg::ST_VBAR;
						CH_AMP:   nxt.state = asl_pkg::ST_AMP;
						CH_LT:    nxt.state = asl_pkg::ST_LT;
						CH_GT:    nxt.state = asl_pkg::ST_GT;
						CH_BANG:  nxt.state = asl_pkg::ST_BANG;
						CH_HAT:   begin b = mk_tok(asl_pkg::T_HAT);   b_v = 1'b1; end
						CH_COMMA: begin b = mk_tok(asl_pkg::T_COMMA); b_v = 1'b1; end
						CH_PLUS:  begin b = mk_tok(asl_pkg::T_PLUS);  b_v = 1'b1; end
						CH_MINUS: begin b = mk_tok(asl_pkg::T_MINUS); b_v = 1'b1; end
						CH_AST:   begin b = mk_tok(asl_pkg::T_AST);   b_v = 1'b1; end
						CH_SLASH: begin b = mk_tok(asl_pkg::T_SLASH); b_v = 1'b1; end
						CH_PCT:   begin b = mk_tok(asl_pkg::T_PCT);   b_v = 1'b1; end
						CH_PARL:  begin b = mk_tok(asl_pkg::T_PARL);  b_v = 1'b1; end
						CH_PARR:  begin b = mk_tok(asl_pkg::T_PARR);  b_v = 1'b1; end
						CH_BRKL:  begin b = mk_tok(asl_pkg::T_BRKL);  b_v = 1'b1; end
						CH_BRKR:  begin b = mk_tok(asl_pkg::T_BRKR);  b_v = 1'b1; end
						CH_BRCL:  begin b = mk_tok(asl_pkg::T_BRCL);  b_v = 1'b1; end
						CH_BRCR:  begin b = mk_tok(asl_pkg::T_BRCR);  b_v = 1'b1; end
						default:  begin b = mk_err(asl_pkg::E_INVALID); b_v = 1'b1; end
					endcase
				end
			end
		end

		res.cnt = a_n + {1'b0, b_v};
		res.slot[0] = (a_n != 2'd0) ? a0 : b;
		res.slot[1] = (a_n == 2'd2) ? a1 : b;
		res.slot[2] = b;
	end

endmodule

/* src/assembler_source_lexer.sv */
// Top level of the assembler source lexer: input stage, lexer registers, result group.
// Depends on asl_pkg and asl_step.
// Each byte is registered in the input stage, then its results load the result group.
// Throughput: one byte per cycle while each byte causes at most one result and out_ready
// is high; a byte with more results holds the next byte with results until its last leaves.
// CR bytes are taken and dropped. Reset (arst_n low, asynchronous): line top, line zero, no beat.
`timescale 1ns / 1ps

module assembler_source_lexer #(
	parameter int VALUE_WIDTH = 32,
	parameter int LINE_WIDTH  = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [7:0]              char_in,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [1:0]              item_kind,
	output logic [5:0]              token_code,
	output logic [7:0]              text_byte,
	output logic [VALUE_WIDTH-1:0]  number_value,
	output logic [LINE_WIDTH-1:0]   line_number,
	output logic [2:0]              error_code,
	output logic                    last_of_run
);

	// input stage
	logic                    valid_s1;
	logic [7:0]              char_s1;

	// lexer registers
	asl_pkg::lex_regs_t      regs_q;
	logic [VALUE_WIDTH-1:0]  acc_q;
	logic [LINE_WIDTH-1:0]   line_q;

	// result group: all results of one byte, drained one beat at a time
	logic [1:0]              grp_cnt_q;
	logic [1:0]              grp_ptr_q;
	asl_pkg::res_t [2:0]     grp_slot_q;
	logic [VALUE_WIDTH-1:0]  grp_val_q;
	logic [LINE_WIDTH-1:0]   grp_line_q;

	asl_pkg::lex_regs_t      regs_d;
	logic [VALUE_WIDTH-1:0]  acc_d;
	asl_pkg::step_out_t      step_res;
	logic [VALUE_WIDTH-1:0]  step_val;
	logic [LINE_WIDTH-1:0]   line_next;
	logic                    grp_last;
	logic                    grp_free;
	logic                    s1_adv;
	logic                    grp_load;
	asl_pkg::res_t           cur_slot;

	asl_step #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_step (
		.cur       (regs_q),
		.cur_acc   (acc_q),
		.ch        (char_s1),
		.nxt       (regs_d),
		.nxt_acc   (acc_d),
		.res       (step_res),
		.num_value (step_val)
	);

	// line number that goes with every result of this byte; saturate at the top
	assign line_next = (&line_q) ? line_q : line_q + 1'b1;

	assign out_valid = (grp_ptr_q != grp_cnt_q);
	assign grp_last  = ((grp_ptr_q + 2'd1) == grp_cnt_q);
	// group register frees up when empty or when its last beat leaves now
	assign grp_free  = !out_valid || (out_ready && grp_last);
	// a byte without results never waits for the group
	assign s1_adv    = valid_s1 && ((step_res.cnt == 2'd0) || grp_free);
	assign grp_load  = s1_adv && (step_res.cnt != 2'd0);
	assign in_ready  = !valid_s1 || s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			// drop carriage returns at the door
			valid_s1 <= in_valid && (char_in != asl_pkg::CH_CR);
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			char_s1 <= char_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= '{state: asl_pkg::ST_TOP, quote: asl_pkg::Q_NONE, len: 3'd0};
			acc_q  <= '0;
			line_q <= '0;
		end else if (s1_adv) begin
			regs_q <= regs_d;
			acc_q  <= acc_d;
			// advance the line count after the results of a line feed
			if ((char_s1 == asl_pkg::CH_LF) && !(&line_q)) begin
				line_q <= line_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_cnt_q <= 2'd0;
			grp_ptr_q <= 2'd0;
		end else if (grp_load) begin
			grp_cnt_q <= step_res.cnt;
			grp_ptr_q <= 2'd0;
		end else if (out_valid && out_ready) begin
			grp_ptr_q <= grp_ptr_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (grp_load) begin
			grp_slot_q <= step_res.slot;
			grp_val_q  <= step_val;
			grp_line_q <= line_next;
		end
	end

	// present the current beat of the group
	assign cur_slot     = grp_slot_q[grp_ptr_q];
	assign item_kind    = cur_slot.kind;
	assign token_code   = cur_slot.code;
	assign text_byte    = cur_slot.text;
	assign error_code   = cur_slot.err;
	assign line_number  = grp_line_q;
	assign last_of_run  = grp_last;
	// the value rides only on a number token
	assign number_value = ((cur_slot.kind == asl_pkg::KIND_TOKEN)
		&& (cur_slot.code == asl_pkg::T_NUM)) ? grp_val_q : '0;

endmodule
